[hdl/mkh_pkg.sv]
// Package for the MurmurHash2 key hash unit: constants, codes and control types.
package mkh_pkg;

    localparam int          DEF_MAX_KEY_BYTES = 64;
    localparam logic [31:0] MUL_M             = 32'h5bd1e995;
    localparam logic [31:0] RST_SEED          = 32'd97;
    localparam logic [6:0]  RST_KEY_LENGTH    = 7'd32;
    localparam int          SHIFT_K           = 24;
    localparam int          SHIFT_F1          = 13;
    localparam int          SHIFT_F2          = 15;

    localparam int          CFG_IDX_W         = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MIX_K,
        OP_MIX_H,
        OP_TAIL,
        OP_FINAL
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX_K,
        S_MIX_H,
        S_TAIL,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic has_full;
        logic has_tail;
        logic in_last;
        logic last_q;
        logic out_free;
    } t_dp_stat;

endpackage

[hdl/mkh_key_if.sv]
// Key word input channel: valid/ready with key word and last flag.
interface mkh_key_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_word;
    logic        last;

    modport source (output valid, output key_word, output last, input ready);
    modport sink   (input valid, input key_word, input last, output ready);
endinterface

[hdl/mkh_hash_if.sv]
// Hash result output channel: valid/ready with 32-bit hash value.
interface mkh_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

[hdl/mkh_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
interface mkh_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mkh_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/mkh_ctrl.sv]
// Controller FSM: sequences the shared multiplier steps for each key word.
module mkh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mkh_pkg::t_dp_stat i_stat,
    output mkh_pkg::t_dp_cmd  o_cmd
);
    import mkh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.op     = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.has_full) begin
                        n_state = S_MIX_K;
                    end else if (i_stat.has_tail) begin
                        n_state = S_TAIL;
                    end else if (i_stat.in_last) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_MIX_K: begin
                o_cmd.op = OP_MIX_K;
                n_state  = S_MIX_H;
            end
            S_MIX_H: begin
                o_cmd.op = OP_MIX_H;
                n_state  = i_stat.last_q ? S_FINAL : S_IDLE;
            end
            S_TAIL: begin
                o_cmd.op = OP_TAIL;
                n_state  = i_stat.last_q ? S_FINAL : S_IDLE;
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_FINAL;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/mkh_datapath.sv]
// Datapath: config registers, hash state, shared constant multiplier, output register.
module mkh_datapath #(
    parameter int MAX_KEY_BYTES = mkh_pkg::DEF_MAX_KEY_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_key_word,
    input  logic              i_last,
    input  mkh_pkg::t_dp_cmd  i_cmd,
    output mkh_pkg::t_dp_stat o_stat,
    mkh_cfg_if.sink           cfg,
    mkh_hash_if.source        hash
);
    import mkh_pkg::*;

    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

    function automatic logic [LEN_W-1:0] f_eff_len(input logic [6:0] klen);
        logic [CMP_W-1:0] l_ext;
        logic [CMP_W-1:0] l_max;
        l_ext = CMP_W'(klen);
        l_max = CMP_W'(MAX_KEY_BYTES);
        return (l_ext > l_max) ? LEN_W'(l_max) : LEN_W'(l_ext);
    endfunction

    logic [31:0]      r_seed;
    logic [6:0]       r_klen;
    logic [31:0]      r_h;
    logic [31:0]      r_k;
    logic [31:0]      r_w;
    logic             r_last;
    logic [LEN_W-1:0] r_seen;
    logic [31:0]      r_hash;
    logic             r_out_valid;

    logic [31:0]      n_h;
    logic [LEN_W-1:0] n_seen;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] remain;
    logic             has_data;
    logic [31:0]      tail_mask;
    logic [31:0]      mul_a;
    logic [31:0]      prod;
    logic             cfg_wr;

    assign eff_len  = f_eff_len(r_klen);
    assign remain   = eff_len - r_seen;
    assign has_data = r_seen < eff_len;
    assign cfg_wr   = cfg.valid && cfg.ready;

    always_comb begin
        case (remain[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'hffff_ffff;
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            OP_NONE:  mul_a = i_key_word;
            OP_MIX_K: mul_a = r_k ^ (r_k >> SHIFT_K);
            OP_MIX_H: mul_a = r_h;
            OP_TAIL:  mul_a = r_h ^ (r_w & tail_mask);
            OP_FINAL: mul_a = r_h ^ (r_h >> SHIFT_F1);
            default:  mul_a = i_key_word;
        endcase
    end

    assign prod = mul_a * MUL_M;

    // a register write restarts the key and wins over a step in the same cycle
    always_comb begin
        n_h    = r_h;
        n_seen = r_seen;
        case (i_cmd.op)
            OP_MIX_H: begin
                n_h    = prod ^ r_k;
                n_seen = r_seen + LEN_W'(4);
            end
            OP_TAIL: begin
                n_h    = prod;
                n_seen = eff_len;
            end
            OP_FINAL: begin
                n_h    = r_seed ^ 32'(eff_len);
                n_seen = '0;
            end
            default: begin
            end
        endcase
        if (cfg_wr) begin
            if (cfg.index == REG_HASH_SEED) begin
                n_h    = cfg.data ^ 32'(eff_len);
                n_seen = '0;
            end else if (cfg.index == REG_KEY_LENGTH) begin
                n_h    = r_seed ^ 32'(f_eff_len(cfg.data[6:0]));
                n_seen = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= RST_SEED;
            r_klen      <= RST_KEY_LENGTH;
            r_h         <= RST_SEED ^ 32'(f_eff_len(RST_KEY_LENGTH));
            r_seen      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_h    <= n_h;
            r_seen <= n_seen;
            if (hash.ready && (i_cmd.op != OP_FINAL)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_w    <= i_key_word;
                r_last <= i_last;
                r_k    <= prod;
            end
            case (i_cmd.op)
                OP_MIX_K: begin
                    r_k <= prod;
                end
                OP_FINAL: begin
                    r_hash      <= prod ^ (prod >> SHIFT_F2);
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
            if (cfg_wr) begin
                if (cfg.index == REG_HASH_SEED) begin
                    r_seed <= cfg.data;
                end else if (cfg.index == REG_KEY_LENGTH) begin
                    r_klen <= cfg.data[6:0];
                end
            end
        end
    end

    assign cfg.ready       = 1'b1;
    assign hash.valid      = r_out_valid;
    assign hash.hash_value = r_hash;

    assign o_stat.has_full = has_data && (remain >= LEN_W'(4));
    assign o_stat.has_tail = has_data && (remain < LEN_W'(4));
    assign o_stat.in_last  = i_last;
    assign o_stat.last_q   = r_last;
    assign o_stat.out_free = !r_out_valid || hash.ready;

endmodule

[hdl/murmur2_key_hash_unit.sv]
// Top level: 32-bit MurmurHash2 of a streamed key; one key word per transfer.
// Full word: accept + two multiplier steps; tail word: accept + tail step; ignored word: accept.
// A word marked last adds a finalize step; the hash sits in the output register the cycle after it.
// Finalize stalls while the previous hash waits; no new word is accepted meanwhile.
// Reset: synchronous active-low; seed 97, key length 32, hash restarted, output empty.
// Any write to the seed or key-length register restarts the key in progress.
module murmur2_key_hash_unit #(
    parameter int MAX_KEY_BYTES = mkh_pkg::DEF_MAX_KEY_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mkh_key_if.sink    i_key_ch,
    mkh_hash_if.source o_hash_ch,
    mkh_cfg_if.sink    i_cfg_ch
);
    import mkh_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    mkh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key_ch.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mkh_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_word (i_key_ch.key_word),
        .i_last     (i_key_ch.last),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .cfg        (i_cfg_ch),
        .hash       (o_hash_ch)
    );

    assign i_key_ch.ready = in_ready;

`ifndef NO_ASSERTIONS
    a_final_needs_free_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_FINAL) |-> stat.out_free)
        else $error("finalize issued while output register occupied");

    a_result_from_finalize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_hash_ch.valid) |-> $past(cmd.op == OP_FINAL))
        else $error("result appeared without a finalize step");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op != OP_NONE) |-> !cmd.accept)
        else $error("transfer accepted during a multiplier step");
`endif

endmodule
